// ===== rtl/bws_pkg.sv =====
// Shared types, widths and codes of the bandwidth supervisor.
`timescale 1ns / 1ps
package bws_pkg;

	// Field and table widths.
	localparam int BW_W       = 21;
	localparam int SUM_W      = 27;
	localparam int COEFF_FRAC = 16;
	localparam int COEFF_W    = COEFF_FRAC + 1;
	localparam int ACT_W      = 2;
	localparam int SLOT_W     = 6;
	localparam int USER_W     = 4;
	localparam int LEVEL_W    = 1;
	localparam int STATUS_W   = 2;
	localparam int CFG_IDX_W  = 2;

	localparam logic [COEFF_W-1:0] COEFF_UNIT = {1'b1, {COEFF_FRAC{1'b0}}};
	localparam logic [BW_W-1:0] BW_UNIT = {1'b1, {(BW_W-1){1'b0}}};

	typedef enum logic [ACT_W-1:0] {
		ACT_ADMIT,
		ACT_SET_REQ,
		ACT_QUERY,
		ACT_RELEASE
	} action_t;

	typedef enum logic [STATUS_W-1:0] {
		STATUS_OK,
		STATUS_UNAUTH,
		STATUS_OVERLOAD,
		STATUS_INVALID
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_UTIL_BOUND,
		REG_SPARE,
		REG_LEVEL0_MAX,
		REG_LEVEL1_MAX
	} cfg_reg_t;

	// One server table entry.
	typedef struct packed {
		logic [BW_W-1:0]    requested;
		logic [BW_W-1:0]    guaranteed;
		logic [BW_W-1:0]    used;
		logic [LEVEL_W-1:0] level;
		logic [USER_W-1:0]  user;
		logic [BW_W-1:0]    user_max;
	} srv_entry_t;

	// One user table entry.
	typedef struct packed {
		logic [SUM_W-1:0]   requested;
		logic [COEFF_W-1:0] coeff;
		logic [SUM_W-1:0]   guaranteed;
		logic [SUM_W-1:0]   used;
	} usr_entry_t;

	localparam usr_entry_t USR_RESET = '{
		requested: '0, coeff: COEFF_UNIT, guaranteed: '0, used: '0
	};

	// Command to the coefficient divider.
	typedef struct packed {
		logic             start;
		logic [BW_W-1:0]  top;
		logic [SUM_W-1:0] sub;
		logic [SUM_W-1:0] den;
	} div_cmd_t;

	// Response of the coefficient divider.
	typedef struct packed {
		logic               busy;
		logic               done;
		logic [COEFF_W-1:0] coeff;
	} div_rsp_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_READ,
		S_CHECK,
		S_USER,
		S_QMUL1,
		S_QMUL2,
		S_QSUM,
		S_SR_SAT,
		S_SR_SUMS,
		S_SR_UDIV,
		S_SR_UWAIT,
		S_LVL,
		S_LVL_WAIT,
		S_RELEASE,
		S_RESP
	} state_t;

endpackage

// ===== rtl/bws_req_if.sv =====
// Request channel carrying one input item of the bandwidth supervisor.
`timescale 1ns / 1ps
interface bws_req_if;
	import bws_pkg::*;

	logic               valid;
	logic               ready;
	logic [ACT_W-1:0]   action;
	logic [SLOT_W-1:0]  server_slot;
	logic [USER_W-1:0]  user_slot;
	logic [LEVEL_W-1:0] server_level;
	logic [BW_W-1:0]    guaranteed_bw;
	logic [BW_W-1:0]    user_max_bw;
	logic [BW_W-1:0]    user_max_guaranteed;
	logic [BW_W-1:0]    requested_bw;

	modport source (
		output valid, action, server_slot, user_slot, server_level,
		       guaranteed_bw, user_max_bw, user_max_guaranteed, requested_bw,
		input  ready
	);

	modport sink (
		input  valid, action, server_slot, user_slot, server_level,
		       guaranteed_bw, user_max_bw, user_max_guaranteed, requested_bw,
		output ready
	);

endinterface

// ===== rtl/bws_rsp_if.sv =====
// Response channel carrying one result item of the bandwidth supervisor.
`timescale 1ns / 1ps
interface bws_rsp_if;
	import bws_pkg::*;

	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [BW_W-1:0]     approved_bw;

	modport source (output valid, status, approved_bw, input ready);
	modport sink (input valid, status, approved_bw, output ready);

endinterface

// ===== rtl/bws_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
`timescale 1ns / 1ps
module bws_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== rtl/bws_ratio_div.sv =====
// Iterative divider that forms a clamped 16-bit-fraction coefficient.
`timescale 1ns / 1ps
module bws_ratio_div (
	input  logic               clk,
	input  logic               arst_n,
	input  bws_pkg::div_cmd_t  cmd,
	output bws_pkg::div_rsp_t  rsp
);
	import bws_pkg::*;

	localparam int CNT_W = $clog2(COEFF_FRAC + 1);

	logic                  busy_q;
	logic                  done_q;
	logic                  unit_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [SUM_W-1:0]      rem_q;
	logic [SUM_W-1:0]      den_q;
	logic [COEFF_FRAC-1:0] quo_q;
	logic [SUM_W-1:0]      top_ext;
	logic [SUM_W-1:0]      num;
	logic                  saturate;
	logic [SUM_W:0]        shifted;
	logic                  fits;

	// The numerator is clamped at zero; a quotient of one or more saturates.
	always_comb begin
		top_ext  = SUM_W'(cmd.top);
		num      = (top_ext > cmd.sub) ? (top_ext - cmd.sub) : '0;
		saturate = (cmd.den == '0) || (num >= cmd.den);
		shifted  = {rem_q, 1'b0};
		fits     = shifted >= {1'b0, den_q};
	end

	// Control: one quotient bit per cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			unit_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (cmd.start) begin
				unit_q <= saturate;
				if (saturate) begin
					done_q <= 1'b1;
				end else begin
					busy_q <= 1'b1;
					cnt_q  <= CNT_W'(COEFF_FRAC);
				end
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Restoring long division of the remainder.
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			rem_q <= num;
			den_q <= cmd.den;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= fits ? SUM_W'(shifted - {1'b0, den_q}) : SUM_W'(shifted);
			quo_q <= {quo_q[COEFF_FRAC-2:0], fits};
		end
	end

	assign rsp.busy  = busy_q;
	assign rsp.done  = done_q;
	assign rsp.coeff = unit_q ? COEFF_UNIT : {1'b0, quo_q};

	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.start |-> !busy_q) else $error("divider restarted while busy");
	a_last_step: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && cnt_q == CNT_W'(1) && !cmd.start) |=> done_q)
		else $error("divider missed its completion");
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q) else $error("divider completion held");

endmodule

// ===== rtl/bandwidth_supervisor.sv =====
// Bandwidth supervisor over server, user and priority-level tables.
//
// Items arrive on the req channel (valid/ready) and each gives exactly one
// item on the rsp channel: a status and, for a query, the approved bandwidth.
// Configuration registers are written through cfg_we/cfg_index/cfg_data; the
// user must do so only while the block is idle, which the block does not enforce.
// One item is processed at a time. A set request, or a release of a slot
// with a request, runs the shared divider once for the user coefficient when
// the user is compressed and once per priority level with demand above its
// guarantee, in level order: at most 1 + NUM_LEVELS divisions per item. The
// server and user tables sit in RAMs with registered reads.
// Reset clears the slot valid bits, the user valid bits, the level tables
// and the totals at once; a user entry never written reads as its reset
// value. No clearing pass is needed. If the receiver stalls, the result
// waits in the output register; the next item is accepted meanwhile and
// its result is held until the output register is free.
`timescale 1ns / 1ps
module bandwidth_supervisor #(
	parameter int NUM_SERVERS = 64,
	parameter int NUM_USERS   = 16,
	parameter int NUM_LEVELS  = 2
) (
	input  logic                           clk,
	input  logic                           arst_n,
	bws_req_if.sink                        req,
	bws_rsp_if.source                      rsp,
	input  logic                           cfg_we,
	input  logic [bws_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [bws_pkg::BW_W-1:0]       cfg_data
);
	import bws_pkg::*;

	localparam int SW  = $clog2(NUM_SERVERS);
	localparam int UW  = NUM_USERS > 1 ? $clog2(NUM_USERS) : 1;
	localparam int LW  = NUM_LEVELS > 1 ? $clog2(NUM_LEVELS) : 1;
	localparam int SRV_W = $bits(srv_entry_t);
	localparam int USR_W = $bits(usr_entry_t);
	localparam int PROD_W = BW_W + COEFF_W;

	state_t state_q, state_d;

	// Latched input item.
	action_t            act_q;
	logic [SLOT_W-1:0]  slot_q;
	logic [USER_W-1:0]  user_in_q;
	logic [LEVEL_W-1:0] level_in_q;
	logic [BW_W-1:0]    gua_q;
	logic [BW_W-1:0]    umax_in_q;
	logic [BW_W-1:0]    umaxg_q;
	logic [BW_W-1:0]    req_in_q;

	// Configuration registers.
	logic [BW_W-1:0] ub_q, spare_q, l0max_q, l1max_q;

	// Tables kept in flip-flops.
	logic [NUM_SERVERS-1:0] srv_valid_q;
	logic [NUM_USERS-1:0]   usr_valid_q;
	logic                   usr_hit_q;
	logic [SUM_W-1:0]       total_gua_q;
	logic [SUM_W-1:0]       lvl_req_q   [NUM_LEVELS];
	logic [SUM_W-1:0]       lvl_gua_q   [NUM_LEVELS];
	logic [COEFF_W-1:0]     lvl_coeff_q [NUM_LEVELS];

	// Working registers.
	logic [BW_W-1:0]   reqsat_q, used_q, avail_q;
	logic [SUM_W-1:0]  uug_q, ureq_q;
	logic [LW-1:0]     k_q;
	logic [PROD_W-1:0] p1_q, p2_q;
	status_t           res_status_q;
	logic [BW_W-1:0]   res_bw_q;
	logic              rsp_valid_q;
	status_t           rsp_status_q;
	logic [BW_W-1:0]   rsp_bw_q;

	// RAM ports.
	logic             srv_re, srv_we;
	logic [SRV_W-1:0] srv_rdata;
	srv_entry_t       srv_rd, srv_wd;
	logic             usr_re, usr_we;
	logic [UW-1:0]    usr_raddr, usr_waddr;
	logic [USR_W-1:0] usr_rdata;
	usr_entry_t       usr_eff, usr_wd;

	div_cmd_t div_cmd;
	div_rsp_t div_rsp;

	// Decoded values.
	logic [31:0]      slot_ext;
	logic [SW-1:0]    sidx;
	logic             in_range;
	logic [UW-1:0]    uidx_in, uidx_srv;
	logic [LW-1:0]    sl;
	logic             admit_bad;
	logic [BW_W-1:0]  limit;
	logic [SUM_W:0]   tsum, usum;
	status_t          admit_status;
	logic [BW_W-1:0]  op_req, reqsat;
	logic [SUM_W-1:0] delta, uug_new, ureq_new, lvl_req_new;
	logic [SUM_W-1:0] ur_min_old, ur_min_new;
	logic             udiv_need;
	logic             usr_commit, rel_commit, lvl_enter;
	logic [COEFF_W-1:0] ucoeff_new;
	logic [BW_W-1:0]  lmax_raw, lmax, asg;
	logic [SUM_W-1:0] lr_min;
	logic             lvl_need, lvl_step, lvl_last;
	logic [COEFF_W-1:0] lcoeff_new;
	logic [BW_W-1:0]  qx;

	// Index decoding and table reads.
	always_comb begin
		slot_ext = 32'(slot_q);
		sidx     = slot_ext[SW-1:0];
		in_range = slot_ext < NUM_SERVERS;
		uidx_in  = UW'(32'(user_in_q));
		srv_rd   = srv_entry_t'(srv_rdata);
		uidx_srv = UW'(32'(srv_rd.user));
		sl       = LW'(32'(srv_rd.level));
		usr_eff  = usr_hit_q ? usr_entry_t'(usr_rdata) : USR_RESET;
	end

	// Admission checks against the user and global bounds.
	always_comb begin
		admit_bad = srv_valid_q[sidx] || (32'(user_in_q) >= NUM_USERS)
		            || (32'(level_in_q) >= NUM_LEVELS);
		limit = (ub_q > spare_q) ? (ub_q - spare_q) : '0;
		tsum  = {1'b0, total_gua_q} + (SUM_W + 1)'(gua_q);
		usum  = {1'b0, usr_eff.guaranteed} + (SUM_W + 1)'(gua_q);
		priority if (admit_bad)                          admit_status = STATUS_INVALID;
		else if (gua_q > umaxg_q)                        admit_status = STATUS_UNAUTH;
		else if (tsum > (SUM_W + 1)'(limit))             admit_status = STATUS_OVERLOAD;
		else if (usum > (SUM_W + 1)'(limit))             admit_status = STATUS_OVERLOAD;
		else if (usum > (SUM_W + 1)'(umaxg_q))           admit_status = STATUS_UNAUTH;
		else                                             admit_status = STATUS_OK;
	end

	// Request update arithmetic.
	always_comb begin
		op_req      = (act_q == ACT_RELEASE) ? '0 : req_in_q;
		reqsat      = (op_req > srv_rd.user_max) ? srv_rd.user_max : op_req;
		delta       = SUM_W'(used_q) - SUM_W'(srv_rd.used);
		uug_new     = usr_eff.used + delta;
		ureq_new    = usr_eff.requested - SUM_W'(srv_rd.requested) + SUM_W'(reqsat_q);
		ur_min_old  = (usr_eff.requested < SUM_W'(srv_rd.user_max))
		              ? usr_eff.requested : SUM_W'(srv_rd.user_max);
		ur_min_new  = (ureq_new < SUM_W'(srv_rd.user_max))
		              ? ureq_new : SUM_W'(srv_rd.user_max);
		lvl_req_new = lvl_req_q[sl] - ur_min_old + ur_min_new;
		udiv_need   = ureq_q > SUM_W'(srv_rd.user_max);
		usr_commit  = (state_q == S_SR_UDIV && !udiv_need)
		              || (state_q == S_SR_UWAIT && div_rsp.done)
		              || (state_q == S_RELEASE);
		rel_commit  = usr_commit && (act_q == ACT_RELEASE);
		lvl_enter   = usr_commit && (state_q != S_RELEASE);
		ucoeff_new  = (state_q == S_SR_UWAIT) ? div_rsp.coeff : COEFF_UNIT;
	end

	// Level grant for the level under work.
	always_comb begin
		if (32'(k_q) == 0) begin
			lmax_raw = l0max_q;
		end else if (32'(k_q) == 1) begin
			lmax_raw = l1max_q;
		end else begin
			lmax_raw = ub_q;
		end
		lmax       = (lmax_raw < ub_q) ? lmax_raw : ub_q;
		lr_min     = (lvl_req_q[k_q] < SUM_W'(lmax)) ? lvl_req_q[k_q] : SUM_W'(lmax);
		asg        = (lr_min < SUM_W'(avail_q)) ? BW_W'(lr_min) : avail_q;
		lvl_need   = lvl_req_q[k_q] > lvl_gua_q[k_q];
		lvl_step   = (state_q == S_LVL && !lvl_need)
		             || (state_q == S_LVL_WAIT && div_rsp.done);
		lvl_last   = 32'(k_q) == NUM_LEVELS - 1;
		lcoeff_new = (state_q == S_LVL_WAIT) ? div_rsp.coeff : COEFF_UNIT;
		qx         = srv_rd.requested - srv_rd.used;
	end

	// Sequencer: next state and memory controls.
	always_comb begin
		state_d   = state_q;
		req.ready = 1'b0;
		srv_re    = 1'b0;
		srv_we    = 1'b0;
		srv_wd    = srv_rd;
		usr_re    = 1'b0;
		usr_raddr = uidx_in;
		usr_we    = 1'b0;
		usr_waddr = uidx_srv;
		usr_wd    = usr_eff;
		div_cmd   = '0;
		unique case (state_q)
			S_IDLE: begin
				req.ready = 1'b1;
				if (req.valid) begin
					state_d = S_READ;
				end
			end
			S_READ: begin
				if (!in_range) begin
					state_d = S_RESP;
				end else begin
					srv_re  = 1'b1;
					usr_re  = 1'b1;
					state_d = S_CHECK;
				end
			end
			S_CHECK: begin
				if (act_q == ACT_ADMIT) begin
					state_d = S_RESP;
					if (admit_status == STATUS_OK) begin
						srv_we = 1'b1;
						srv_wd = '{requested: '0, guaranteed: gua_q, used: '0,
						           level: level_in_q, user: user_in_q,
						           user_max: umax_in_q};
						usr_we    = 1'b1;
						usr_waddr = uidx_in;
						usr_wd.guaranteed = SUM_W'(usum);
					end
				end else if (!srv_valid_q[sidx]) begin
					state_d = S_RESP;
				end else begin
					usr_re    = 1'b1;
					usr_raddr = uidx_srv;
					state_d   = S_USER;
				end
			end
			S_USER: begin
				unique case (act_q)
					ACT_QUERY:   state_d = S_QMUL1;
					ACT_SET_REQ: state_d = S_SR_SAT;
					ACT_RELEASE: state_d = (srv_rd.requested != '0) ? S_SR_SAT : S_RELEASE;
					default:     state_d = S_RESP;
				endcase
			end
			S_QMUL1: state_d = S_QMUL2;
			S_QMUL2: state_d = S_QSUM;
			S_QSUM:  state_d = S_RESP;
			S_SR_SAT: state_d = S_SR_SUMS;
			S_SR_SUMS: begin
				srv_we           = 1'b1;
				srv_wd.requested = reqsat_q;
				srv_wd.used      = used_q;
				state_d          = S_SR_UDIV;
			end
			S_SR_UDIV: begin
				if (udiv_need) begin
					div_cmd.start = 1'b1;
					div_cmd.top   = srv_rd.user_max;
					div_cmd.sub   = uug_q;
					div_cmd.den   = ureq_q - uug_q;
					state_d       = S_SR_UWAIT;
				end else begin
					state_d = S_LVL;
				end
			end
			S_SR_UWAIT: begin
				if (div_rsp.done) begin
					state_d = S_LVL;
				end
			end
			S_LVL: begin
				if (lvl_need) begin
					div_cmd.start = 1'b1;
					div_cmd.top   = asg;
					div_cmd.sub   = lvl_gua_q[k_q];
					div_cmd.den   = lvl_req_q[k_q] - lvl_gua_q[k_q];
					state_d       = S_LVL_WAIT;
				end else if (lvl_last) begin
					state_d = S_RESP;
				end
			end
			S_LVL_WAIT: begin
				if (div_rsp.done) begin
					state_d = lvl_last ? S_RESP : S_LVL;
				end
			end
			S_RELEASE: state_d = S_RESP;
			S_RESP: begin
				if (!rsp_valid_q || rsp.ready) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
		// The user entry is written back once its coefficient is known.
		if (usr_commit) begin
			usr_we            = 1'b1;
			usr_waddr         = uidx_srv;
			usr_wd.used       = (state_q == S_RELEASE) ? usr_eff.used : uug_q;
			usr_wd.requested  = (state_q == S_RELEASE) ? usr_eff.requested : ureq_q;
			usr_wd.coeff      = (state_q == S_RELEASE) ? usr_eff.coeff : ucoeff_new;
			usr_wd.guaranteed = rel_commit
			                    ? usr_eff.guaranteed - SUM_W'(srv_rd.guaranteed)
			                    : usr_eff.guaranteed;
		end
	end

	// State register and tables with a reset value.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			ub_q        <= BW_UNIT;
			spare_q     <= '0;
			l0max_q     <= BW_UNIT;
			l1max_q     <= BW_UNIT;
			srv_valid_q <= '0;
			usr_valid_q <= '0;
			total_gua_q <= '0;
			rsp_valid_q <= 1'b0;
			for (int i = 0; i < NUM_LEVELS; i++) begin
				lvl_req_q[i]   <= '0;
				lvl_gua_q[i]   <= '0;
				lvl_coeff_q[i] <= COEFF_UNIT;
			end
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				unique case (cfg_reg_t'(cfg_index))
					REG_UTIL_BOUND: ub_q    <= cfg_data;
					REG_SPARE:      spare_q <= cfg_data;
					REG_LEVEL0_MAX: l0max_q <= cfg_data;
					REG_LEVEL1_MAX: l1max_q <= cfg_data;
				endcase
			end
			if (usr_we) begin
				usr_valid_q[usr_waddr] <= 1'b1;
			end
			if (state_q == S_CHECK && act_q == ACT_ADMIT && admit_status == STATUS_OK) begin
				srv_valid_q[sidx] <= 1'b1;
				total_gua_q       <= SUM_W'(tsum);
			end
			if (rel_commit) begin
				srv_valid_q[sidx] <= 1'b0;
				total_gua_q       <= total_gua_q - SUM_W'(srv_rd.guaranteed);
			end
			if (state_q == S_SR_SUMS) begin
				lvl_gua_q[sl] <= lvl_gua_q[sl] + delta;
				lvl_req_q[sl] <= lvl_req_new;
			end
			if (lvl_step) begin
				lvl_coeff_q[k_q] <= lcoeff_new;
			end
			if (state_q == S_RESP && state_d == S_IDLE) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Working and payload registers.
	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			act_q        <= action_t'(req.action);
			slot_q       <= req.server_slot;
			user_in_q    <= req.user_slot;
			level_in_q   <= req.server_level;
			gua_q        <= req.guaranteed_bw;
			umax_in_q    <= req.user_max_bw;
			umaxg_q      <= req.user_max_guaranteed;
			req_in_q     <= req.requested_bw;
			res_status_q <= STATUS_OK;
			res_bw_q     <= '0;
		end
		if (usr_re) begin
			usr_hit_q <= usr_valid_q[usr_raddr];
		end
		if (state_q == S_READ && !in_range) begin
			res_status_q <= STATUS_INVALID;
		end
		if (state_q == S_CHECK) begin
			if (act_q == ACT_ADMIT) begin
				res_status_q <= admit_status;
			end else if (!srv_valid_q[sidx]) begin
				res_status_q <= STATUS_INVALID;
			end
		end
		if (state_q == S_SR_SAT) begin
			reqsat_q <= reqsat;
			used_q   <= (reqsat < srv_rd.guaranteed) ? reqsat : srv_rd.guaranteed;
		end
		if (state_q == S_SR_SUMS) begin
			uug_q  <= uug_new;
			ureq_q <= ureq_new;
		end
		if (lvl_enter) begin
			k_q     <= '0;
			avail_q <= ub_q;
		end
		if (state_q == S_LVL) begin
			avail_q <= avail_q - asg;
		end
		if (lvl_step && !lvl_last) begin
			k_q <= k_q + LW'(1);
		end
		// Query: the used bandwidth plus the excess request scaled by both coefficients.
		if (state_q == S_QMUL1) begin
			p1_q <= PROD_W'(qx) * PROD_W'(usr_eff.coeff);
		end
		if (state_q == S_QMUL2) begin
			p2_q <= PROD_W'(p1_q[COEFF_FRAC +: BW_W]) * PROD_W'(lvl_coeff_q[sl]);
		end
		if (state_q == S_QSUM) begin
			res_bw_q <= srv_rd.used + p2_q[COEFF_FRAC +: BW_W];
		end
		if (state_q == S_RESP && state_d == S_IDLE) begin
			rsp_status_q <= res_status_q;
			rsp_bw_q     <= res_bw_q;
		end
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.status      = rsp_status_q;
	assign rsp.approved_bw = rsp_bw_q;

	bws_ram #(
		.WIDTH (SRV_W),
		.DEPTH (NUM_SERVERS)
	) u_srv_ram (
		.clk   (clk),
		.we    (srv_we),
		.waddr (sidx),
		.wdata (SRV_W'(srv_wd)),
		.re    (srv_re),
		.raddr (sidx),
		.rdata (srv_rdata)
	);

	bws_ram #(
		.WIDTH (USR_W),
		.DEPTH (NUM_USERS)
	) u_usr_ram (
		.clk   (clk),
		.we    (usr_we),
		.waddr (usr_waddr),
		.wdata (USR_W'(usr_wd)),
		.re    (usr_re),
		.raddr (usr_raddr),
		.rdata (usr_rdata)
	);

	bws_ratio_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (div_cmd),
		.rsp    (div_rsp)
	);

	a_accept_reads: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> (state_q == S_READ))
		else $error("accepted item did not start a table read");
	a_busy_no_accept: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.busy |-> !req.ready) else $error("item accepted during a division");
	a_bw_only_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && rsp_bw_q != '0) |-> (rsp_status_q == STATUS_OK))
		else $error("approved bandwidth on a failed item");

endmodule

// ===== dv/bandwidth_supervisor_tb.sv =====
// Self-checking testbench of the bandwidth supervisor with its own table predictor.
`timescale 1ns / 1ps
module bandwidth_supervisor_tb;
	import bws_pkg::*;

	localparam int N_SRV = 64;
	localparam int N_USR = 16;
	localparam int N_LVL = 2;
	localparam longint CYCLE_LIMIT = 400000;
	localparam logic [63:0] M21 = (64'd1 << 21) - 1;
	localparam logic [63:0] M27 = (64'd1 << 27) - 1;
	localparam logic [63:0] ONE_C = 64'd1 << 16;
	localparam logic [63:0] ONE_BW = 64'd1 << 20;

	// One stimulus row; chk_* hold a typed-in result where want is set.
	typedef struct {
		action_t        act;
		logic [5:0]     slot;
		logic [3:0]     usr;
		logic           lvl;
		logic [20:0]    gua;
		logic [20:0]    umax;
		logic [20:0]    umaxg;
		logic [20:0]    reqbw;
		bit             want;
		status_t        chk_status;
		logic [20:0]    chk_bw;
	} row_t;

	typedef struct {
		status_t     st;
		logic [20:0] bw;
	} verdict_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [BW_W-1:0] cfg_data = '0;

	bws_req_if req ();
	bws_rsp_if rsp ();

	bandwidth_supervisor u_dut (
		.clk(clk), .arst_n(arst_n), .req(req.sink), .rsp(rsp.source),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #2 clk = ~clk;

	// Shadow of the configuration and tables.
	logic [63:0] bound_r, spare_r, lmax_r [N_LVL];
	bit          s_valid [N_SRV];
	logic [63:0] s_req [N_SRV], s_gua [N_SRV], s_used [N_SRV], s_umax [N_SRV];
	int          s_lvl [N_SRV], s_usr [N_SRV];
	logic [63:0] u_req [N_USR], u_coeff [N_USR], u_gua [N_USR], u_used [N_USR];
	logic [63:0] l_req [N_LVL], l_coeff [N_LVL], l_gua [N_LVL];
	logic [63:0] tot_gua, tot_used;

	verdict_t awaited [$];
	int  mismatches = 0;
	int  idle_pct = 0, stall_pct = 0;
	longint cycles = 0;

	function automatic logic [63:0] min64(logic [63:0] a, logic [63:0] b);
		return a < b ? a : b;
	endfunction

	// Compression coefficient: clamped numerator over divisor, at most one.
	function automatic logic [63:0] coeff_of(logic [63:0] top, logic [63:0] sub,
			logic [63:0] den);
		logic [63:0] num;
		num = top > sub ? top - sub : 0;
		if (den == 0)
			return ONE_C;
		return min64((num << 16) / den, ONE_C);
	endfunction

	task automatic shadow_reset();
		bound_r = ONE_BW;
		spare_r = 0;
		foreach (lmax_r[i]) lmax_r[i] = ONE_BW;
		foreach (s_valid[i]) begin
			s_valid[i] = 0; s_req[i] = 0; s_gua[i] = 0; s_used[i] = 0;
			s_umax[i] = 0; s_lvl[i] = 0; s_usr[i] = 0;
		end
		foreach (u_req[i]) begin
			u_req[i] = 0; u_coeff[i] = ONE_C; u_gua[i] = 0; u_used[i] = 0;
		end
		foreach (l_req[i]) begin
			l_req[i] = 0; l_coeff[i] = ONE_C; l_gua[i] = 0;
		end
		tot_gua = 0;
		tot_used = 0;
	endtask

	// Request update and coefficient recomputation for one server.
	function automatic void apply_request(int s, logic [63:0] r);
		int u, l;
		logic [63:0] used, delta, ureq, avail, asg, lm;
		u = s_usr[s];
		l = s_lvl[s];
		if (r > s_umax[s]) r = s_umax[s];
		used = min64(r, s_gua[s]);
		delta = used - s_used[s];
		u_used[u] = (u_used[u] + delta) & M27;
		l_gua[l] = (l_gua[l] + delta) & M27;
		tot_used = (tot_used + delta) & M27;
		s_used[s] = used;
		ureq = (u_req[u] - s_req[s] + r) & M27;
		if (ureq > s_umax[s])
			u_coeff[u] = coeff_of(s_umax[s], u_used[u], (ureq - u_used[u]) & M27);
		else
			u_coeff[u] = ONE_C;
		l_req[l] = (l_req[l] - min64(u_req[u], s_umax[s]) + min64(ureq, s_umax[s])) & M27;
		s_req[s] = r;
		u_req[u] = ureq;
		avail = bound_r;
		for (int k = 0; k < N_LVL; k++) begin
			lm = min64(lmax_r[k], bound_r);
			asg = min64(min64(l_req[k], lm), avail);
			if (l_req[k] > l_gua[k])
				l_coeff[k] = coeff_of(asg, l_gua[k], l_req[k] - l_gua[k]);
			else
				l_coeff[k] = ONE_C;
			avail -= asg;
		end
	endfunction

	// Predicted result of one accepted item; updates the shadow tables.
	function automatic verdict_t predict_verdict(row_t it);
		verdict_t v;
		int s;
		logic [63:0] limit, x;
		v.st = STATUS_OK;
		v.bw = '0;
		s = it.slot;
		if (it.act == ACT_ADMIT) begin
			limit = bound_r > spare_r ? bound_r - spare_r : 0;
			if (s_valid[s])
				v.st = STATUS_INVALID;
			else if (it.gua > it.umaxg)
				v.st = STATUS_UNAUTH;
			else if (tot_gua + it.gua > limit)
				v.st = STATUS_OVERLOAD;
			else if (u_gua[it.usr] + it.gua > limit)
				v.st = STATUS_OVERLOAD;
			else if (u_gua[it.usr] + it.gua > it.umaxg)
				v.st = STATUS_UNAUTH;
			else begin
				s_valid[s] = 1; s_req[s] = 0; s_gua[s] = it.gua; s_used[s] = 0;
				s_lvl[s] = it.lvl; s_usr[s] = it.usr; s_umax[s] = it.umax;
				tot_gua = (tot_gua + it.gua) & M27;
				u_gua[it.usr] = (u_gua[it.usr] + it.gua) & M27;
			end
		end else if (!s_valid[s]) begin
			v.st = STATUS_INVALID;
		end else if (it.act == ACT_SET_REQ) begin
			apply_request(s, it.reqbw);
		end else if (it.act == ACT_QUERY) begin
			x = s_req[s] - s_used[s];
			x = (x * u_coeff[s_usr[s]]) >> 16;
			x = (x * l_coeff[s_lvl[s]]) >> 16;
			v.bw = 21'((s_used[s] + x) & M21);
		end else begin
			if (s_req[s] != 0)
				apply_request(s, 0);
			tot_gua = (tot_gua - s_gua[s]) & M27;
			u_gua[s_usr[s]] = (u_gua[s_usr[s]] - s_gua[s]) & M27;
			s_valid[s] = 0;
		end
		return v;
	endfunction

	// Cycle counter and timeout.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// Receiver: random stalls, compares each result with the oldest prediction.
	always @(posedge clk) begin
		verdict_t e;
		if (arst_n && rsp.valid && rsp.ready) begin
			if (awaited.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: status %0d bw %0d", rsp.status,
						rsp.approved_bw);
			end else begin
				e = awaited.pop_front();
				if (rsp.status !== e.st || rsp.approved_bw !== e.bw) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected status %0d bw %0d, got %0d %0d",
							e.st, e.bw, rsp.status, rsp.approved_bw);
				end
			end
		end
		rsp.ready <= ($urandom_range(99) >= stall_pct);
	end

	task automatic send_item(row_t it);
		verdict_t v;
		while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
			req.valid <= 1'b0;
			@(posedge clk);
		end
		req.valid <= 1'b1;
		req.action <= it.act;
		req.server_slot <= it.slot;
		req.user_slot <= it.usr;
		req.server_level <= it.lvl;
		req.guaranteed_bw <= it.gua;
		req.user_max_bw <= it.umax;
		req.user_max_guaranteed <= it.umaxg;
		req.requested_bw <= it.reqbw;
		do @(posedge clk); while (!req.ready);
		v = predict_verdict(it);
		if (it.want && (v.st != it.chk_status || v.bw != it.chk_bw)) begin
			mismatches++;
			if (mismatches <= 10)
				$display("table row disagrees with predictor: %0d/%0d vs %0d/%0d",
					it.chk_status, it.chk_bw, v.st, v.bw);
		end
		awaited.push_back(v);
	endtask

	// Waits until the block has delivered everything, then lets it settle.
	task automatic drain();
		req.valid <= 1'b0;
		@(posedge clk);
		while (awaited.size() != 0) @(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	task automatic write_reg(cfg_reg_t idx, logic [63:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val[20:0];
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_UTIL_BOUND: bound_r = val & M21;
			REG_SPARE:      spare_r = val & M21;
			REG_LEVEL0_MAX: lmax_r[0] = val & M21;
			default:        lmax_r[1] = val & M21;
		endcase
	endtask

	function automatic row_t mk(action_t a, int s, int u, int l, int g, int um,
			int umg, int r);
		row_t it;
		it.act = a; it.slot = 6'(s); it.usr = 4'(u); it.lvl = 1'(l); it.gua = 21'(g);
		it.umax = 21'(um); it.umaxg = 21'(umg); it.reqbw = 21'(r); it.want = 0;
		it.chk_status = STATUS_OK; it.chk_bw = '0;
		return it;
	endfunction

	function automatic row_t mkc(row_t it, status_t st, int bw);
		it.want = 1; it.chk_status = st; it.chk_bw = 21'(bw);
		return it;
	endfunction

	// Random item, mostly aimed at live slots with well-formed values.
	function automatic row_t rand_item();
		row_t it;
		int pick;
		pick = $urandom_range(99);
		it = mk(ACT_QUERY, $urandom_range(15), $urandom_range(3), $urandom_range(1),
			$urandom_range(200000), $urandom_range(1048576), $urandom_range(1048576),
			$urandom_range(600000));
		if (pick < 20) begin
			it.act = ACT_ADMIT;
			it.umaxg = ($urandom_range(3) == 0) ? 21'($urandom_range(2097151))
			                                    : 21'(1048576);
		end else if (pick < 55)
			it.act = ACT_SET_REQ;
		else if (pick < 80)
			it.act = ACT_QUERY;
		else if (pick < 92)
			it.act = ACT_RELEASE;
		else begin
			it.act = action_t'($urandom_range(3));
			it.slot = 6'($urandom_range(63));
			it.usr = 4'($urandom_range(15));
			it.gua = 21'($urandom_range(2097151));
			it.umax = 21'($urandom_range(2097151));
			it.reqbw = 21'($urandom_range(2097151));
		end
		return it;
	endfunction

	row_t dir_rows [$];

	initial begin
		req.valid = 1'b0;
		req.action = ACT_ADMIT;
		req.server_slot = '0;
		req.user_slot = '0;
		req.server_level = '0;
		req.guaranteed_bw = '0;
		req.user_max_bw = '0;
		req.user_max_guaranteed = '0;
		req.requested_bw = '0;
		shadow_reset();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table: free slots, bounds, every action, saturation cases.
		dir_rows = '{
			mkc(mk(ACT_QUERY, 0, 0, 0, 0, 0, 0, 0), STATUS_INVALID, 0),
			mkc(mk(ACT_SET_REQ, 63, 0, 0, 0, 0, 0, 5), STATUS_INVALID, 0),
			mkc(mk(ACT_RELEASE, 5, 0, 0, 0, 0, 0, 0), STATUS_INVALID, 0),
			mkc(mk(ACT_ADMIT, 1, 0, 0, 100, 1048576, 50, 0), STATUS_UNAUTH, 0),
			mkc(mk(ACT_ADMIT, 1, 0, 0, 2097151, 2097151, 2097151, 0),
				STATUS_OVERLOAD, 0),
			mkc(mk(ACT_ADMIT, 1, 15, 1, 262144, 524288, 1048576, 0), STATUS_OK, 0),
			mkc(mk(ACT_ADMIT, 1, 15, 1, 0, 0, 0, 0), STATUS_INVALID, 0),
			mkc(mk(ACT_ADMIT, 63, 0, 0, 0, 2097151, 0, 0), STATUS_OK, 0),
			mk(ACT_ADMIT, 2, 15, 1, 262144, 524288, 300000, 0),
			mk(ACT_SET_REQ, 1, 0, 0, 0, 0, 0, 2097151),
			mk(ACT_QUERY, 1, 0, 0, 0, 0, 0, 0),
			mk(ACT_ADMIT, 3, 15, 0, 100000, 524288, 1048576, 0),
			mk(ACT_SET_REQ, 3, 0, 0, 0, 0, 0, 400000),
			mk(ACT_QUERY, 3, 0, 0, 0, 0, 0, 0),
			mk(ACT_SET_REQ, 63, 0, 0, 0, 0, 0, 1048576),
			mk(ACT_QUERY, 63, 0, 0, 0, 0, 0, 0),
			mk(ACT_SET_REQ, 1, 0, 0, 0, 0, 0, 0),
			mk(ACT_QUERY, 1, 0, 0, 0, 0, 0, 0),
			mkc(mk(ACT_RELEASE, 1, 0, 0, 0, 0, 0, 0), STATUS_OK, 0),
			mkc(mk(ACT_RELEASE, 2, 0, 0, 0, 0, 0, 0), STATUS_INVALID, 0),
			mk(ACT_RELEASE, 3, 0, 0, 0, 0, 0, 0),
			mk(ACT_QUERY, 63, 0, 0, 0, 0, 0, 0),
			mk(ACT_RELEASE, 63, 0, 0, 0, 0, 0, 0)
		};
		foreach (dir_rows[i])
			send_item(dir_rows[i]);
		drain();

		// Configuration extremes: spare above bound blocks any guarantee.
		write_reg(REG_SPARE, 1048576);
		write_reg(REG_UTIL_BOUND, 0);
		send_item(mkc(mk(ACT_ADMIT, 4, 0, 0, 1, 10, 10, 0), STATUS_OVERLOAD, 0));
		send_item(mkc(mk(ACT_ADMIT, 4, 0, 0, 0, 10, 10, 0), STATUS_OK, 0));
		send_item(mk(ACT_SET_REQ, 4, 0, 0, 0, 0, 0, 10));
		send_item(mk(ACT_QUERY, 4, 0, 0, 0, 0, 0, 0));
		send_item(mk(ACT_RELEASE, 4, 0, 0, 0, 0, 0, 0));
		drain();

		// Random phases under several settings and idling patterns.
		for (int ph = 0; ph < 5; ph++) begin
			case (ph)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 67; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 67; end
				3: begin idle_pct = 16; stall_pct = 16; end
				default: begin idle_pct = 0; stall_pct = 0; end
			endcase
			write_reg(REG_UTIL_BOUND, ph == 4 ? 1048576 : $urandom_range(300000, 1048576));
			write_reg(REG_SPARE, ph == 4 ? 0 : $urandom_range(200000));
			write_reg(REG_LEVEL0_MAX, ph == 2 ? 0 : $urandom_range(1048576));
			write_reg(REG_LEVEL1_MAX, ph == 3 ? 2097151 : $urandom_range(1048576));
			for (int n = 0; n < 100; n++)
				send_item(rand_item());
			drain();
		end

		if (mismatches == 0 && awaited.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

// ===== bandwidth_supervisor.f =====
rtl/bws_pkg.sv
rtl/bws_req_if.sv
rtl/bws_rsp_if.sv
rtl/bws_ram.sv
rtl/bws_ratio_div.sv
rtl/bandwidth_supervisor.sv
dv/bandwidth_supervisor_tb.sv
